// File: hdl/sgts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgts_pkg;

	localparam int MAX_DIM_X  = 32;
	localparam int MAX_DIM_Y  = 32;
	localparam int MAX_DIM_Z  = 16;
	localparam int CELL_SHIFT = 1;
	localparam int FRAC_BITS  = 16;

	localparam int CELL_BITS  = FRAC_BITS - CELL_SHIFT;
	localparam int STORE_SIZE = (MAX_DIM_X + 1) * (MAX_DIM_Y + 1) * (MAX_DIM_Z + 1);
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int DIM_W      = 6;
	localparam int EXZ_W      = 10;
	localparam int PROD_W     = 33 + FRAC_BITS + 1;

	localparam logic [33:0] CELL_HALF = (CELL_BITS > 0) ? (34'd1 << (CELL_BITS - 1)) : 34'd0;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_SIZE - 1);

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		MODE_CENTRED = 2'd0,
		MODE_X       = 2'd1,
		MODE_Y       = 2'd2,
		MODE_Z       = 2'd3
	} face_t;

	typedef enum logic [2:0] {
		REG_FACE_MODE = 3'd0,
		REG_DEFAULT   = 3'd1,
		REG_DIM_X     = 3'd2,
		REG_DIM_Y     = 3'd3,
		REG_DIM_Z     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_REPLY,
		ST_CLEAR,
		ST_READ,
		ST_MUL,
		ST_ADD
	} back_state_t;

	typedef logic [DIM_W-1:0] dim_t;

	typedef struct packed {
		face_t              mode;
		logic signed [31:0] dval;
		logic [5:0]         dim_x;
		logic [5:0]         dim_y;
		logic [4:0]         dim_z;
	} cfg_t;

	typedef struct packed {
		act_t               kind;
		logic               drop;
		dim_t               ix;
		dim_t               iy;
		dim_t               iz;
		logic [15:0]        fx;
		logic [15:0]        fy;
		logic [15:0]        fz;
		logic signed [31:0] wval;
	} entry_t;

	typedef struct packed {
		logic [2:0] a_i;
		logic [2:0] b_i;
		logic [2:0] dst;
		axis_t      axis;
	} lerp_sel_t;

	function automatic dim_t dim_eff(input cfg_t c, input axis_t a);
		dim_t raw;
		dim_t mx;
		unique case (a)
			AX_X: begin
				raw = c.dim_x;
				mx = DIM_W'(MAX_DIM_X);
			end
			AX_Y: begin
				raw = c.dim_y;
				mx = DIM_W'(MAX_DIM_Y);
			end
			default: begin
				raw = DIM_W'(c.dim_z);
				mx = DIM_W'(MAX_DIM_Z);
			end
		endcase
		if (raw == '0)
			return DIM_W'(1);
		if (raw > mx)
			return mx;
		return raw;
	endfunction

	function automatic logic is_stag(input cfg_t c, input axis_t a);
		return 2'(c.mode) == (2'(a) + 2'd1);
	endfunction

	function automatic dim_t ext_eff(input cfg_t c, input axis_t a);
		return dim_eff(c, a) + DIM_W'(is_stag(c, a));
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input dim_t cx, input dim_t cy,
			input dim_t cz, input dim_t ext_x, input logic [EXZ_W-1:0] exz);
		logic [16:0] s;
		s = 17'(cx) + 17'(cz) * 17'(ext_x) + 17'(cy) * 17'(exz);
		return s[ADDR_W-1:0];
	endfunction

	// blend along y, then x, then z; corner index is {dx, dy, dz}
	function automatic lerp_sel_t lerp_sel(input logic [2:0] step);
		lerp_sel_t r;
		unique case (step)
			3'd0: r = '{a_i: 3'd0, b_i: 3'd2, dst: 3'd0, axis: AX_Y};
			3'd1: r = '{a_i: 3'd4, b_i: 3'd6, dst: 3'd4, axis: AX_Y};
			3'd2: r = '{a_i: 3'd1, b_i: 3'd3, dst: 3'd1, axis: AX_Y};
			3'd3: r = '{a_i: 3'd5, b_i: 3'd7, dst: 3'd5, axis: AX_Y};
			3'd4: r = '{a_i: 3'd0, b_i: 3'd4, dst: 3'd0, axis: AX_X};
			3'd5: r = '{a_i: 3'd1, b_i: 3'd5, dst: 3'd1, axis: AX_X};
			default: r = '{a_i: 3'd0, b_i: 3'd1, dst: 3'd0, axis: AX_Z};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/sgts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sgts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/sgts_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sgts_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [1:0]          action,
	input  wire logic [5:0]          cell_x,
	input  wire logic [5:0]          cell_y,
	input  wire logic [4:0]          cell_z,
	input  wire logic signed [31:0]  write_value,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic signed [31:0]  pos_z,
	input  wire sgts_pkg::cfg_t      cfg,
	output logic                     push,
	output sgts_pkg::entry_t         entry
);

	logic                valid_s1;
	sgts_pkg::act_t      act_s1;
	logic [5:0]          cx_s1;
	logic [5:0]          cy_s1;
	logic [4:0]          cz_s1;
	logic signed [31:0]  wval_s1;
	logic signed [31:0]  px_s1;
	logic signed [31:0]  py_s1;
	logic signed [31:0]  pz_s1;

	sgts_pkg::dim_t      ix, iy, iz;
	logic [15:0]         fx, fy, fz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_s1 <= sgts_pkg::act_t'(action);
			cx_s1 <= cell_x;
			cy_s1 <= cell_y;
			cz_s1 <= cell_z;
			wval_s1 <= write_value;
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			pz_s1 <= pos_z;
		end
	end

	function automatic void split(input logic signed [31:0] pos, input sgts_pkg::axis_t a,
			input sgts_pkg::cfg_t c, output sgts_pkg::dim_t idx, output logic [15:0] frac);
		logic signed [33:0] p;
		logic signed [33:0] lim;
		p = 34'(pos) - (sgts_pkg::is_stag(c, a) ? 34'sd0 : $signed(sgts_pkg::CELL_HALF));
		lim = $signed(34'(sgts_pkg::ext_eff(c, a)) << sgts_pkg::CELL_BITS);
		if (p < 0)
			p = '0;
		if (p > lim)
			p = lim;
		idx = sgts_pkg::DIM_W'(p >>> sgts_pkg::CELL_BITS);
		frac = 16'((34'(p) & ((34'd1 << sgts_pkg::CELL_BITS) - 34'd1)) << sgts_pkg::CELL_SHIFT);
	endfunction

	always_comb begin
		split(px_s1, sgts_pkg::AX_X, cfg, ix, fx);
		split(py_s1, sgts_pkg::AX_Y, cfg, iy, fy);
		split(pz_s1, sgts_pkg::AX_Z, cfg, iz, fz);
		push = valid_s1;
		entry.kind = act_s1;
		entry.drop = (act_s1 == sgts_pkg::ACT_WRITE) &&
			((cx_s1 >= sgts_pkg::ext_eff(cfg, sgts_pkg::AX_X)) ||
			 (cy_s1 >= sgts_pkg::ext_eff(cfg, sgts_pkg::AX_Y)) ||
			 (6'(cz_s1) >= sgts_pkg::ext_eff(cfg, sgts_pkg::AX_Z)));
		entry.wval = wval_s1;
		entry.fx = fx;
		entry.fy = fy;
		entry.fz = fz;
		if (act_s1 == sgts_pkg::ACT_WRITE) begin
			entry.ix = cx_s1;
			entry.iy = cy_s1;
			entry.iz = 6'(cz_s1);
		end else begin
			entry.ix = ix;
			entry.iy = iy;
			entry.iz = iz;
		end
	end

endmodule
`default_nettype wire

// File: hdl/sgts_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module sgts_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sgts_pkg::entry_t din,
	input  wire logic             pop,
	output sgts_pkg::entry_t      head,
	output logic                  empty
);

	sgts_pkg::entry_t slot_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= din;
	end

	assign head = slot_q[rp_q];
	assign empty = (count_q == 2'd0);

endmodule
`default_nettype wire

// File: hdl/sgts_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sgts_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sgts_pkg::cfg_t     cfg,
	input  wire logic               q_empty,
	input  wire sgts_pkg::entry_t   q_head,
	output logic                    pop,
	output logic                    active,
	output logic                    done,
	output logic signed [31:0]      sample_value,
	output logic                    write_dropped
);

	sgts_pkg::back_state_t state_q, state_d;
	sgts_pkg::entry_t      ent_q;
	logic [sgts_pkg::ADDR_W-1:0] cnt_q;
	logic [3:0]            k_q;
	logic [2:0]            step_q;
	logic signed [31:0]    v_q [8];
	logic                  rd_s2;
	logic [2:0]            slot_s2;
	logic                  off_s2;
	logic signed [sgts_pkg::PROD_W-1:0] prod_q;
	logic signed [31:0]    a_q;
	logic [sgts_pkg::EXZ_W-1:0] exz_q;
	logic                  done_q;
	logic signed [31:0]    value_q;
	logic                  drop_q;

	logic                  we;
	logic [sgts_pkg::ADDR_W-1:0] waddr;
	logic [31:0]           wdata;
	logic [sgts_pkg::ADDR_W-1:0] raddr;
	logic [31:0]           rdata;
	logic                  rd_issue;
	logic                  emit;
	logic signed [31:0]    emit_val;
	logic                  emit_drop;

	sgts_pkg::dim_t        ext_x, ext_z;
	sgts_pkg::dim_t        cx, cy, cz;
	logic                  off;
	sgts_pkg::lerp_sel_t   sel;
	logic [15:0]           t_sel;
	logic signed [32:0]    diff;
	logic signed [sgts_pkg::PROD_W-1:0] rounded;
	logic signed [31:0]    lerp_res;

	function automatic void corner(input sgts_pkg::dim_t idx, input logic bit_d,
			input sgts_pkg::cfg_t c, input sgts_pkg::axis_t a,
			output sgts_pkg::dim_t cc, output logic o);
		logic [6:0] v;
		logic       strict;
		sgts_pkg::dim_t d;
		v = 7'(idx) + 7'(bit_d);
		d = sgts_pkg::dim_eff(c, a);
		strict = (c.mode == sgts_pkg::MODE_CENTRED) || sgts_pkg::is_stag(c, a);
		o = strict && (v >= 7'(sgts_pkg::ext_eff(c, a)));
		if (!strict && (v > 7'(d - 6'd1)))
			v = 7'(d - 6'd1);
		cc = v[5:0];
	endfunction

	sgts_ram #(.WIDTH(32), .DEPTH(sgts_pkg::STORE_SIZE)) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		logic ox, oy, oz;
		ext_x = sgts_pkg::ext_eff(cfg, sgts_pkg::AX_X);
		ext_z = sgts_pkg::ext_eff(cfg, sgts_pkg::AX_Z);
		corner(ent_q.ix, k_q[2], cfg, sgts_pkg::AX_X, cx, ox);
		corner(ent_q.iy, k_q[1], cfg, sgts_pkg::AX_Y, cy, oy);
		corner(ent_q.iz, k_q[0], cfg, sgts_pkg::AX_Z, cz, oz);
		off = ox || oy || oz;
		raddr = off ? '0 : sgts_pkg::cell_addr(cx, cy, cz, ext_x, exz_q);
	end

	always_comb begin
		sel = sgts_pkg::lerp_sel(step_q);
		unique case (sel.axis)
			sgts_pkg::AX_X: t_sel = ent_q.fx;
			sgts_pkg::AX_Y: t_sel = ent_q.fy;
			default: t_sel = ent_q.fz;
		endcase
		diff = 33'(v_q[sel.b_i]) - 33'(v_q[sel.a_i]);
		rounded = (prod_q + $signed(sgts_pkg::ROUND_HALF)) >>> sgts_pkg::FRAC_BITS;
		lerp_res = a_q + 32'(rounded);
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		we = 1'b0;
		waddr = cnt_q;
		wdata = cfg.dval;
		rd_issue = 1'b0;
		emit = 1'b0;
		emit_val = '0;
		emit_drop = 1'b0;
		unique case (state_q)
			sgts_pkg::ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (q_head.kind)
						sgts_pkg::ACT_WRITE:
							state_d = q_head.drop ? sgts_pkg::ST_REPLY : sgts_pkg::ST_WRITE;
						sgts_pkg::ACT_SAMPLE: state_d = sgts_pkg::ST_READ;
						sgts_pkg::ACT_CLEAR: state_d = sgts_pkg::ST_CLEAR;
						default: state_d = sgts_pkg::ST_REPLY;
					endcase
				end
			end
			sgts_pkg::ST_WRITE: begin
				we = 1'b1;
				waddr = sgts_pkg::cell_addr(ent_q.ix, ent_q.iy, ent_q.iz, ext_x, exz_q);
				wdata = ent_q.wval;
				emit = 1'b1;
				state_d = sgts_pkg::ST_IDLE;
			end
			sgts_pkg::ST_REPLY: begin
				emit = 1'b1;
				emit_drop = ent_q.drop;
				state_d = sgts_pkg::ST_IDLE;
			end
			sgts_pkg::ST_CLEAR: begin
				we = 1'b1;
				if (cnt_q == sgts_pkg::ADDR_LAST) begin
					emit = 1'b1;
					state_d = sgts_pkg::ST_IDLE;
				end
			end
			sgts_pkg::ST_READ: begin
				if (!k_q[3])
					rd_issue = 1'b1;
				else
					state_d = sgts_pkg::ST_MUL;
			end
			sgts_pkg::ST_MUL: state_d = sgts_pkg::ST_ADD;
			sgts_pkg::ST_ADD: begin
				if (step_q == 3'd6) begin
					emit = 1'b1;
					emit_val = lerp_res;
					state_d = sgts_pkg::ST_IDLE;
				end else begin
					state_d = sgts_pkg::ST_MUL;
				end
			end
			default: state_d = sgts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgts_pkg::ST_IDLE;
			done_q <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= emit;
			rd_s2 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		exz_q <= sgts_pkg::EXZ_W'(ext_x) * sgts_pkg::EXZ_W'(ext_z);
		value_q <= emit_val;
		drop_q <= emit_drop;
		slot_s2 <= k_q[2:0];
		off_s2 <= off;
		if (pop) begin
			ent_q <= q_head;
			cnt_q <= '0;
			k_q <= '0;
			step_q <= '0;
		end
		if (state_q == sgts_pkg::ST_CLEAR)
			cnt_q <= cnt_q + 1'b1;
		if (rd_issue)
			k_q <= k_q + 4'd1;
		if (rd_s2)
			v_q[slot_s2] <= off_s2 ? cfg.dval : $signed(rdata);
		if (state_q == sgts_pkg::ST_MUL) begin
			a_q <= v_q[sel.a_i];
			prod_q <= sgts_pkg::PROD_W'(diff) *
				sgts_pkg::PROD_W'($signed({1'b0, t_sel}));
		end
		if (state_q == sgts_pkg::ST_ADD) begin
			v_q[sel.dst] <= lerp_res;
			step_q <= step_q + 3'd1;
		end
	end

	assign active = (state_q != sgts_pkg::ST_IDLE);
	assign done = done_q;
	assign sample_value = value_q;
	assign write_dropped = drop_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_no_write_in_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sgts_pkg::ST_READ || state_q == sgts_pkg::ST_MUL ||
		 state_q == sgts_pkg::ST_ADD) |-> !we)
		else $error("grid written during a sample");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == sgts_pkg::ST_IDLE) && !q_empty)
		else $error("word popped outside idle");

	a_lerp_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sgts_pkg::ST_MUL && $past(state_q) == sgts_pkg::ST_READ) |-> !rd_s2)
		else $error("blend started with a read outstanding");

endmodule
`default_nettype wire

// File: hdl/staggered_grid_trilinear_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// Samples a 3-D Q15.16 grid (cell centred or face staggered) trilinearly, writes one
// cell, or clears the grid to default_value. An action is taken when start is high
// and busy is low; its single result appears with done for exactly one cycle and
// must be taken then, as the receiver cannot stall it. A sample makes eight reads
// through the single read port of the grid memory, then seven blends on one shared
// multiplier, and a clear writes one memory word per cycle. Grid contents are
// undefined after reset until written or cleared. Configuration is to be written by the
// user only while busy is low; the block itself does not enforce this.
module staggered_grid_trilinear_sampler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic [5:0]         cell_x,
	input  wire logic [5:0]         cell_y,
	input  wire logic [4:0]         cell_z,
	input  wire logic signed [31:0] write_value,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	output logic                    done,
	output logic signed [31:0]      sample_value,
	output logic                    write_dropped
);

	sgts_pkg::cfg_t   cfg_q;
	sgts_pkg::entry_t entry;
	sgts_pkg::entry_t head;
	logic             take;
	logic             push;
	logic             pop;
	logic             empty;
	logic             active;
	logic             front_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= sgts_pkg::MODE_CENTRED;
			cfg_q.dval <= '0;
			cfg_q.dim_x <= 6'd20;
			cfg_q.dim_y <= 6'd20;
			cfg_q.dim_z <= 5'd10;
		end else if (cfg_we) begin
			unique case (sgts_pkg::reg_idx_t'(cfg_index))
				sgts_pkg::REG_FACE_MODE: cfg_q.mode <= sgts_pkg::face_t'(cfg_wdata[1:0]);
				sgts_pkg::REG_DEFAULT: cfg_q.dval <= $signed(cfg_wdata);
				sgts_pkg::REG_DIM_X: cfg_q.dim_x <= cfg_wdata[5:0];
				sgts_pkg::REG_DIM_Y: cfg_q.dim_y <= cfg_wdata[5:0];
				sgts_pkg::REG_DIM_Z: cfg_q.dim_z <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			front_busy_q <= 1'b0;
		else
			front_busy_q <= take;
	end

	assign take = start && !busy;
	assign busy = front_busy_q || !empty || active;

	sgts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.action      (action),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_z      (cell_z),
		.write_value (write_value),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.cfg         (cfg_q),
		.push        (push),
		.entry       (entry)
	);

	sgts_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	sgts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (empty),
		.q_head        (head),
		.pop           (pop),
		.active        (active),
		.done          (done),
		.sample_value  (sample_value),
		.write_dropped (write_dropped)
	);

endmodule
`default_nettype wire

// File: sim/staggered_grid_trilinear_sampler_tb.sv
`timescale 1ns / 1ps
module staggered_grid_trilinear_sampler_tb;
	import sgts_pkg::*;

	localparam longint CELL_Q = longint'(1) << CELL_BITS;
	localparam longint HALF_Q = CELL_Q >> 1;
	localparam longint ONE_Q = longint'(1) << FRAC_BITS;
	localparam int STALL_LIMIT = 100000;

	typedef struct {
		logic signed [31:0] value;
		logic               dropped;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         action = '0;
	logic [5:0]         cell_x = '0;
	logic [5:0]         cell_y = '0;
	logic [4:0]         cell_z = '0;
	logic signed [31:0] write_value = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_wdata = '0;
	logic               done;
	logic signed [31:0] sample_value;
	logic               write_dropped;

	face_t              m_mode;
	logic signed [31:0] m_dval;
	logic [5:0]         m_dim_x;
	logic [5:0]         m_dim_y;
	logic [4:0]         m_dim_z;
	logic signed [31:0] grid_mem [STORE_SIZE];
	longint             dim_e [3];
	longint             ext_e [3];
	reply_t             pending_replies [$];
	bit                 failed = 1'b0;
	int                 idle_pct = 0;
	int                 stall_count = 0;

	staggered_grid_trilinear_sampler u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z), .write_value(write_value),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .done(done),
		.sample_value(sample_value), .write_dropped(write_dropped)
	);

	always #10 clk = ~clk;

	function automatic longint clamp_dim(input longint raw, input longint mx);
		if (raw < 1)
			return 1;
		if (raw > mx)
			return mx;
		return raw;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint t);
		longint s;
		s = a * (ONE_Q - t) + b * t + (ONE_Q >> 1);
		if (s >= 0)
			return s >>> FRAC_BITS;
		return -(((-s) + ONE_Q - 1) >>> FRAC_BITS);
	endfunction

	function automatic longint fetch_corner(input longint c0, input longint c1,
			input longint c2);
		longint c [3];
		longint addr;
		bit     strict;
		c[0] = c0;
		c[1] = c1;
		c[2] = c2;
		for (int a = 0; a < 3; a++) begin
			strict = (m_mode == MODE_CENTRED) || (int'(m_mode) == a + 1);
			if (strict) begin
				if (c[a] < 0 || c[a] >= ext_e[a])
					return longint'(m_dval);
			end else begin
				if (c[a] < 0)
					c[a] = 0;
				if (c[a] > dim_e[a] - 1)
					c[a] = dim_e[a] - 1;
			end
		end
		addr = c[0] + c[2] * ext_e[0] + c[1] * ext_e[0] * ext_e[2];
		if (addr < 0 || addr >= STORE_SIZE)
			return 0;
		return longint'(grid_mem[addr]);
	endfunction

	task automatic predict_word(input act_t act, input logic [5:0] cx, input logic [5:0] cy,
			input logic [4:0] cz, input logic signed [31:0] wv, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		reply_t r;
		longint pos [3];
		longint idx [3];
		longint frac [3];
		longint v [8];
		longint p;
		longint lim;
		longint addr;
		longint y00, y10, y01, y11, x0, x1;
		dim_e[0] = clamp_dim(m_dim_x, MAX_DIM_X);
		dim_e[1] = clamp_dim(m_dim_y, MAX_DIM_Y);
		dim_e[2] = clamp_dim(m_dim_z, MAX_DIM_Z);
		for (int a = 0; a < 3; a++)
			ext_e[a] = dim_e[a] + ((int'(m_mode) == a + 1) ? 1 : 0);
		r.value = '0;
		r.dropped = 1'b0;
		case (act)
			ACT_WRITE: begin
				if (cx >= ext_e[0] || cy >= ext_e[1] || cz >= ext_e[2]) begin
					r.dropped = 1'b1;
				end else begin
					addr = cx + cz * ext_e[0] + cy * ext_e[0] * ext_e[2];
					if (addr < STORE_SIZE)
						grid_mem[addr] = wv;
				end
			end
			ACT_SAMPLE: begin
				pos[0] = px;
				pos[1] = py;
				pos[2] = pz;
				for (int a = 0; a < 3; a++) begin
					p = pos[a] - ((int'(m_mode) == a + 1) ? 0 : HALF_Q);
					lim = CELL_Q * ext_e[a];
					if (p < 0)
						p = 0;
					if (p > lim)
						p = lim;
					idx[a] = p >>> CELL_BITS;
					frac[a] = (p & (CELL_Q - 1)) << CELL_SHIFT;
				end
				for (int n = 0; n < 8; n++)
					v[n] = fetch_corner(idx[0] + n[2], idx[1] + n[1], idx[2] + n[0]);
				y00 = blend(v[0], v[2], frac[1]);
				y10 = blend(v[4], v[6], frac[1]);
				y01 = blend(v[1], v[3], frac[1]);
				y11 = blend(v[5], v[7], frac[1]);
				x0 = blend(y00, y10, frac[0]);
				x1 = blend(y01, y11, frac[0]);
				r.value = 32'(blend(x0, x1, frac[2]));
			end
			ACT_CLEAR: begin
				for (int n = 0; n < STORE_SIZE; n++)
					grid_mem[n] = m_dval;
			end
			default: begin
			end
		endcase
		pending_replies.push_back(r);
	endtask

	task automatic send_word(input act_t act, input logic [5:0] cx, input logic [5:0] cy,
			input logic [4:0] cz, input logic signed [31:0] wv, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		action <= act;
		cell_x <= cx;
		cell_y <= cy;
		cell_z <= cz;
		write_value <= wv;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_word(act, cx, cy, cz, wv, px, py, pz);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_FACE_MODE: m_mode = face_t'(data[1:0]);
			REG_DEFAULT:   m_dval = data;
			REG_DIM_X:     m_dim_x = data[5:0];
			REG_DIM_Y:     m_dim_y = data[5:0];
			REG_DIM_Z:     m_dim_z = data[4:0];
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_grid(input face_t mode, input logic [31:0] dval, input logic [5:0] dx,
			input logic [5:0] dy, input logic [4:0] dz);
		drain();
		cfg_write(REG_FACE_MODE, 32'(mode));
		cfg_write(REG_DEFAULT, dval);
		cfg_write(REG_DIM_X, 32'(dx));
		cfg_write(REG_DIM_Y, 32'(dy));
		cfg_write(REG_DIM_Z, 32'(dz));
	endtask

	function automatic logic signed [31:0] near_pos(input int axis);
		return 32'($signed($urandom_range(0, int'(CELL_Q * (ext_e[axis] + 2))))
			- int'(CELL_Q));
	endfunction

	function automatic logic [5:0] pick_dim(input int mx);
		case ($urandom_range(7))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'(mx);
			3: return 6'($urandom_range(63));
			default: return 6'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic test_reset_clear;
		predict_word(ACT_NONE, '0, '0, '0, '0, '0, '0, '0);
		void'(pending_replies.pop_back());
		send_word(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0);
		send_word(ACT_SAMPLE, '0, '0, '0, '0, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000);
	endtask

	task automatic test_write_edges;
		set_grid(MODE_CENTRED, 32'h8000_0000, 6'd3, 6'd3, 5'd2);
		send_word(ACT_WRITE, 6'd0, 6'd0, 5'd0, 32'h7FFF_FFFF, '0, '0, '0);
		send_word(ACT_WRITE, 6'd2, 6'd2, 5'd1, 32'h8000_0000, '0, '0, '0);
		send_word(ACT_WRITE, 6'd1, 6'd0, 5'd1, 32'hFFFF_FFFF, '0, '0, '0);
		send_word(ACT_WRITE, 6'd3, 6'd0, 5'd0, 32'h1234_5678, '0, '0, '0);
		send_word(ACT_WRITE, 6'd63, 6'd63, 5'd31, 32'h1234_5678, '0, '0, '0);
		send_word(ACT_NONE, 6'd1, 6'd1, 5'd1, 32'h5555_5555, 32'h1, 32'h1, 32'h1);
	endtask

	task automatic test_sample_modes;
		for (int m = 0; m < 4; m++) begin
			set_grid(face_t'(m), 32'h0001_8000, 6'd3, 6'd3, 5'd2);
			send_word(ACT_SAMPLE, '0, '0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
			send_word(ACT_SAMPLE, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
			send_word(ACT_SAMPLE, '0, '0, '0, '0, 32'h0000_4000, 32'h0000_C000, 32'h0000_6000);
			send_word(ACT_SAMPLE, '0, '0, '0, '0, 32'h0000_8000, 32'h0001_0000, 32'h0000_0000);
		end
		set_grid(MODE_Y, 32'hDEAD_BEEF, 6'd63, 6'd0, 5'd31);
		send_word(ACT_SAMPLE, '0, '0, '0, '0, 32'h0010_0000, 32'h0000_2000, 32'h0004_0000);
	endtask

	task automatic test_random_phase(input int sender_idle, input int count);
		logic [31:0] roll;
		idle_pct = sender_idle;
		for (int k = 0; k < 4; k++) begin
			set_grid(face_t'($urandom_range(3)), ($urandom_range(3) == 0) ?
				{1'($urandom_range(1)), 31'h0} - 32'($urandom_range(1)) : $urandom,
				pick_dim(MAX_DIM_X), pick_dim(MAX_DIM_Y), 5'(pick_dim(MAX_DIM_Z)));
			predict_word(ACT_NONE, '0, '0, '0, '0, '0, '0, '0);
			void'(pending_replies.pop_back());
			if (k == 0)
				send_word(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0);
			for (int n = 0; n < count / 4; n++) begin
				roll = $urandom_range(99);
				if (roll < 40)
					send_word(ACT_WRITE, 6'($urandom_range(int'(ext_e[0]) - 1)),
						6'($urandom_range(int'(ext_e[1]) - 1)),
						5'($urandom_range(int'(ext_e[2]) - 1)), $urandom, $urandom,
						$urandom, $urandom);
				else if (roll < 80)
					send_word(ACT_SAMPLE, 6'($urandom), 6'($urandom), 5'($urandom),
						$urandom, near_pos(0), near_pos(1), near_pos(2));
				else if (roll < 90)
					send_word(ACT_SAMPLE, 6'($urandom), 6'($urandom), 5'($urandom),
						$urandom, $urandom, $urandom, $urandom);
				else if (roll < 96)
					send_word(ACT_WRITE, 6'($urandom), 6'($urandom), 5'($urandom),
						$urandom, $urandom, $urandom, $urandom);
				else
					send_word(ACT_NONE, 6'($urandom), 6'($urandom), 5'($urandom),
						$urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected word: sample_value %h write_dropped %b",
					sample_value, write_dropped);
				failed = 1'b1;
			end else begin
				if (sample_value !== pending_replies[0].value) begin
					$error("sample_value expected %h actual %h",
						pending_replies[0].value, sample_value);
					failed = 1'b1;
				end
				if (write_dropped !== pending_replies[0].dropped) begin
					$error("write_dropped expected %b actual %b",
						pending_replies[0].dropped, write_dropped);
					failed = 1'b1;
				end
				void'(pending_replies.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("staggered_grid_trilinear_sampler verification failed");
			$finish;
		end
	end

	initial begin
		m_mode = MODE_CENTRED;
		m_dval = '0;
		m_dim_x = 6'd20;
		m_dim_y = 6'd20;
		m_dim_z = 5'd10;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_clear();
		test_write_edges();
		test_sample_modes();
		test_random_phase(11, 132);
		test_random_phase(54, 132);
		test_random_phase(0, 136);
		drain();
		repeat (40) @(posedge clk);
		if (!failed)
			$display("staggered_grid_trilinear_sampler verification clean");
		else
			$display("staggered_grid_trilinear_sampler verification failed");
		$finish;
	end

endmodule
